### sv/triple_port_interface_adapter_assert.svh
// Assertion macros for the triple-port interface adapter.
// Each macro takes a label, an antecedent, a consequent and a message.
// They expect signals named clk and rst in the using module.
`ifndef TRIPLE_PORT_INTERFACE_ADAPTER_ASSERT_SVH
`define TRIPLE_PORT_INTERFACE_ADAPTER_ASSERT_SVH

`ifndef SYNTHESIS

`define TPIA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define TPIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TPIA_ASSERT_SAME(lbl, ante, cons, msg)

`define TPIA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/tpia_pkg.sv
`default_nettype none

package tpia_pkg;

  localparam int IRQ_LINES = 5;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_LINE  = 2'd2,
    MODE_PIN   = 2'd3
  } mode_t;

  // register map
  localparam logic [2:0] ADDR_PORT_A = 3'd0;
  localparam logic [2:0] ADDR_PORT_B = 3'd1;
  localparam logic [2:0] ADDR_PORT_C = 3'd2;
  localparam logic [2:0] ADDR_DIR_A  = 3'd3;
  localparam logic [2:0] ADDR_DIR_B  = 3'd4;
  localparam logic [2:0] ADDR_DIR_C  = 3'd5;
  localparam logic [2:0] ADDR_CTRL   = 3'd6;
  localparam logic [2:0] ADDR_AIR    = 3'd7;

  // pin latch select
  localparam logic [1:0] PIN_PORT_A = 2'd0;
  localparam logic [1:0] PIN_PORT_B = 2'd1;
  localparam logic [1:0] PIN_PORT_C = 2'd2;

  // control register bits
  localparam int CTRL_INT_MODE  = 0;
  localparam int CTRL_PRIO      = 1;
  localparam int CTRL_L3_RISE   = 2;
  localparam int CTRL_L4_RISE   = 3;
  localparam int CTRL_CA_LEVEL  = 4;
  localparam int CTRL_CA_MANUAL = 5;
  localparam int CTRL_CB_LEVEL  = 6;
  localparam int CTRL_CB_MANUAL = 7;

  localparam logic [2:0] LINE_3   = 3'd3;
  localparam logic [2:0] LINE_4   = 3'd4;
  localparam logic [2:0] LINE_MAX = 3'd4;

  localparam logic [7:0] READ_IDLE = 8'hff;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [2:0] line_index;
    logic       line_level;
    logic [1:0] pin_port;
    logic [7:0] pin_value;
    logic [7:0] ext_read;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic [7:0] port_c_drive;
    logic       port_c_drive_enable;
    logic       ca_out;
    logic       cb_out;
  } out_t;

endpackage

`default_nettype wire

### sv/triple_port_interface_adapter.sv
// Path: from the input transfer through the input register, then one pass of
//   update logic into the result register, to the result transfer.
// Throughput: one item per cycle while results are taken; the input register
//   absorbs one item while the result register is stalled.
// Reset (rst, synchronous): all state registers clear, pin latches go
//   to all ones, both channels empty.
`default_nettype none

`include "triple_port_interface_adapter_assert.svh"

module triple_port_interface_adapter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tpia_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tpia_pkg::out_t     out_data
);
  import tpia_pkg::*;

  in_t  in_reg;
  logic in_reg_valid;
  logic advance;

  logic [7:0] out_latch_a, out_latch_b, out_latch_c;
  logic [7:0] dir_a, dir_b, dir_c;
  logic [7:0] control;
  logic [IRQ_LINES-1:0] pending_irq;
  logic [IRQ_LINES-1:0] line_levels;
  logic [7:0] pin_latch [3];
  logic ca_level, cb_level;

  logic [7:0] out_latch_a_next, out_latch_b_next, out_latch_c_next;
  logic [7:0] dir_a_next, dir_b_next, dir_c_next;
  logic [7:0] control_next;
  logic [IRQ_LINES-1:0] pending_irq_next;
  logic [IRQ_LINES-1:0] line_levels_next;
  logic [7:0] pin_latch_next [3];
  logic ca_level_next, cb_level_next;
  logic [7:0] read_data_next;
  out_t out_data_next;

  logic irq_active;
  logic [IRQ_LINES-1:0] top_irq;
  logic fire;

  function automatic logic [7:0] mix_port(input logic [7:0] pins, input logic [7:0] ext,
                                          input logic [7:0] dir, input logic [7:0] latch);
    return ((pins & ext) & ~dir) | (dir & latch);
  endfunction

  // request is high exactly while a line is pending
  assign irq_active = |pending_irq;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_reg <= in_data;
    end
  end

  // highest pending line, one-hot
  always_comb begin
    top_irq = '0;
    for (int i = 0; i < IRQ_LINES; i++) begin
      if (pending_irq[i]) begin
        top_irq    = '0;
        top_irq[i] = 1'b1;
      end
    end
  end

  always_comb begin
    if (in_reg.line_index == LINE_3) begin
      fire = control[CTRL_L3_RISE] ? in_reg.line_level : !in_reg.line_level;
    end else if (in_reg.line_index == LINE_4) begin
      fire = control[CTRL_L4_RISE] ? in_reg.line_level : !in_reg.line_level;
    end else begin
      fire = !in_reg.line_level;
    end
  end

  always_comb begin
    out_latch_a_next = out_latch_a;
    out_latch_b_next = out_latch_b;
    out_latch_c_next = out_latch_c;
    dir_a_next       = dir_a;
    dir_b_next       = dir_b;
    dir_c_next       = dir_c;
    control_next     = control;
    pending_irq_next = pending_irq;
    line_levels_next = line_levels;
    pin_latch_next   = pin_latch;
    ca_level_next    = ca_level;
    cb_level_next    = cb_level;
    read_data_next   = READ_IDLE;

    case (in_reg.mode)
      MODE_READ: begin
        case (in_reg.reg_addr)
          ADDR_PORT_A: read_data_next = mix_port(pin_latch[0], in_reg.ext_read, dir_a,
                                                 out_latch_a);
          ADDR_PORT_B: read_data_next = mix_port(pin_latch[1], in_reg.ext_read, dir_b,
                                                 out_latch_b);
          ADDR_PORT_C: begin
            if (control[CTRL_INT_MODE]) begin
              read_data_next = {cb_level, ca_level, !irq_active, line_levels};
            end else begin
              read_data_next = mix_port(pin_latch[2], in_reg.ext_read, dir_c, out_latch_c);
            end
          end
          ADDR_DIR_A: read_data_next = dir_a;
          ADDR_DIR_B: read_data_next = dir_b;
          ADDR_DIR_C: read_data_next = dir_c;
          ADDR_CTRL:  read_data_next = control;
          ADDR_AIR: begin
            if (control[CTRL_PRIO]) begin
              if (top_irq != '0) begin
                read_data_next   = {3'b000, top_irq};
                pending_irq_next = pending_irq & ~top_irq;
              end
            end else begin
              read_data_next   = {3'b000, pending_irq};
              pending_irq_next = '0;
            end
          end
          default: read_data_next = READ_IDLE;
        endcase
      end
      MODE_WRITE: begin
        case (in_reg.reg_addr)
          ADDR_PORT_A: out_latch_a_next = in_reg.write_data;
          ADDR_PORT_B: out_latch_b_next = in_reg.write_data;
          ADDR_PORT_C: out_latch_c_next = in_reg.write_data;
          ADDR_DIR_A:  dir_a_next       = in_reg.write_data;
          ADDR_DIR_B:  dir_b_next       = in_reg.write_data;
          ADDR_DIR_C:  dir_c_next       = in_reg.write_data;
          ADDR_CTRL: begin
            control_next = in_reg.write_data;
            if (in_reg.write_data[CTRL_INT_MODE]) begin
              if (in_reg.write_data[CTRL_CA_MANUAL]) begin
                ca_level_next = in_reg.write_data[CTRL_CA_LEVEL];
              end
              if (in_reg.write_data[CTRL_CB_MANUAL]) begin
                cb_level_next = in_reg.write_data[CTRL_CB_LEVEL];
              end
            end
          end
          default: ;
        endcase
      end
      MODE_LINE: begin
        if (in_reg.line_index <= LINE_MAX && control[CTRL_INT_MODE] &&
            line_levels[in_reg.line_index] != in_reg.line_level) begin
          line_levels_next[in_reg.line_index] = in_reg.line_level;
          if (fire && dir_c[in_reg.line_index]) begin
            pending_irq_next[in_reg.line_index] = 1'b1;
          end
        end
      end
      MODE_PIN: begin
        case (in_reg.pin_port)
          PIN_PORT_A: pin_latch_next[0] = in_reg.pin_value;
          PIN_PORT_B: pin_latch_next[1] = in_reg.pin_value;
          PIN_PORT_C: pin_latch_next[2] = in_reg.pin_value;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_next.read_data           = read_data_next;
    out_data_next.irq_out             = |pending_irq_next;
    out_data_next.port_a_drive        = out_latch_a_next & dir_a_next;
    out_data_next.port_b_drive        = out_latch_b_next & dir_b_next;
    out_data_next.port_c_drive        = control_next[CTRL_INT_MODE] ? 8'h00 :
                                        (out_latch_c_next & dir_c_next);
    out_data_next.port_c_drive_enable = !control_next[CTRL_INT_MODE];
    out_data_next.ca_out              = ca_level_next;
    out_data_next.cb_out              = cb_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_latch_a  <= '0;
      out_latch_b  <= '0;
      out_latch_c  <= '0;
      dir_a        <= '0;
      dir_b        <= '0;
      dir_c        <= '0;
      control      <= '0;
      pending_irq  <= '0;
      line_levels  <= '0;
      pin_latch[0] <= 8'hff;
      pin_latch[1] <= 8'hff;
      pin_latch[2] <= 8'hff;
      ca_level     <= 1'b0;
      cb_level     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        out_latch_a <= out_latch_a_next;
        out_latch_b <= out_latch_b_next;
        out_latch_c <= out_latch_c_next;
        dir_a       <= dir_a_next;
        dir_b       <= dir_b_next;
        dir_c       <= dir_c_next;
        control     <= control_next;
        pending_irq <= pending_irq_next;
        line_levels <= line_levels_next;
        pin_latch   <= pin_latch_next;
        ca_level    <= ca_level_next;
        cb_level    <= cb_level_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  `TPIA_ASSERT_SAME(a_irq_matches_pending, out_valid,
                    out_data.irq_out == (pending_irq != '0),
                    "irq_out disagrees with pending lines")

  `TPIA_ASSERT_SAME(a_port_c_enable_matches_ctrl, out_valid,
                    out_data.port_c_drive_enable == !control[CTRL_INT_MODE],
                    "port C drive enable disagrees with control")

  `TPIA_ASSERT_NEXT(a_latch_needs_dir_c, 1'b1,
                    (pending_irq & ~$past(pending_irq) & ~$past(dir_c[IRQ_LINES-1:0])) == '0,
                    "line latched without its port C direction bit")

  `TPIA_ASSERT_NEXT(a_latch_needs_int_mode, !control[CTRL_INT_MODE],
                    (pending_irq & ~$past(pending_irq)) == '0,
                    "line latched outside interrupt mode")

  `TPIA_ASSERT_NEXT(a_in_reg_holds, in_reg_valid && !advance,
                    in_reg_valid && $stable(in_reg),
                    "held item lost while result stalled")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tpia_pkg::*;

  localparam int RANDOM_OPS   = 1000;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int PRINT_CAP    = 40;
  // selects that name nothing in the block
  localparam logic [1:0] PIN_NONE  = 2'd3;
  localparam logic [2:0] LINE_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  triple_port_interface_adapter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the adapter registers
  logic [7:0] lat_a, lat_b, lat_c;
  logic [7:0] ddr_a, ddr_b, ddr_c;
  logic [7:0] ctrl_reg;
  logic [4:0] irq_pend;
  logic       irq_flag;
  logic [4:0] lines;
  logic [7:0] pins [3];
  logic       ca_lvl, cb_lvl;

  in_t  pending_ops[$];
  out_t predicted_outs[$];
  int   ops_total;
  int   ops_sent = 0;
  int   outs_checked = 0;
  int   err_cnt = 0;
  int   irq_takes = 0;
  int   mode_cnt [4];
  int   eff_cnt = 0;

  function automatic logic [7:0] port_mix(logic [7:0] pin, logic [7:0] ext,
                                          logic [7:0] dir, logic [7:0] lat);
    return ((pin & ext) & ~dir) | (dir & lat);
  endfunction

  function automatic out_t adapter_step(in_t it);
    out_t res;
    logic [7:0] rdat;
    logic fire;
    logic hit;
    rdat = READ_IDLE;
    case (it.mode)
      MODE_READ: begin
        case (it.reg_addr)
          ADDR_PORT_A: rdat = port_mix(pins[0], it.ext_read, ddr_a, lat_a);
          ADDR_PORT_B: rdat = port_mix(pins[1], it.ext_read, ddr_b, lat_b);
          ADDR_PORT_C: begin
            if (ctrl_reg[CTRL_INT_MODE]) rdat = {cb_lvl, ca_lvl, ~irq_flag, lines};
            else rdat = port_mix(pins[2], it.ext_read, ddr_c, lat_c);
          end
          ADDR_DIR_A: rdat = ddr_a;
          ADDR_DIR_B: rdat = ddr_b;
          ADDR_DIR_C: rdat = ddr_c;
          ADDR_CTRL:  rdat = ctrl_reg;
          default: begin
            if (ctrl_reg[CTRL_PRIO]) begin
              // highest pending line only, line 4 first
              hit = 1'b0;
              for (int b = IRQ_LINES - 1; b >= 0; b--) begin
                if (!hit && irq_pend[b]) begin
                  hit = 1'b1;
                  rdat = 8'd1 << b;
                  irq_pend[b] = 1'b0;
                end
              end
            end else begin
              rdat = {3'b000, irq_pend};
              irq_pend = '0;
            end
            irq_flag = |irq_pend;
          end
        endcase
      end
      MODE_WRITE: begin
        case (it.reg_addr)
          ADDR_PORT_A: lat_a = it.write_data;
          ADDR_PORT_B: lat_b = it.write_data;
          ADDR_PORT_C: lat_c = it.write_data;
          ADDR_DIR_A:  ddr_a = it.write_data;
          ADDR_DIR_B:  ddr_b = it.write_data;
          ADDR_DIR_C:  ddr_c = it.write_data;
          ADDR_CTRL: begin
            ctrl_reg = it.write_data;
            if (ctrl_reg[CTRL_INT_MODE]) begin
              if (ctrl_reg[CTRL_CA_MANUAL]) ca_lvl = ctrl_reg[CTRL_CA_LEVEL];
              if (ctrl_reg[CTRL_CB_MANUAL]) cb_lvl = ctrl_reg[CTRL_CB_LEVEL];
            end
          end
          default: ;
        endcase
      end
      MODE_LINE: begin
        if (it.line_index <= LINE_MAX && ctrl_reg[CTRL_INT_MODE] &&
            lines[it.line_index] != it.line_level) begin
          lines[it.line_index] = it.line_level;
          if (it.line_index == LINE_3)
            fire = ctrl_reg[CTRL_L3_RISE] ? it.line_level : !it.line_level;
          else if (it.line_index == LINE_4)
            fire = ctrl_reg[CTRL_L4_RISE] ? it.line_level : !it.line_level;
          else
            fire = !it.line_level;
          if (fire && !irq_pend[it.line_index] && ddr_c[it.line_index]) begin
            irq_pend[it.line_index] = 1'b1;
            irq_flag = 1'b1;
            irq_takes++;
          end
        end
      end
      default: begin
        if (it.pin_port <= PIN_PORT_C) pins[it.pin_port] = it.pin_value;
      end
    endcase
    res.read_data           = rdat;
    res.irq_out             = irq_flag;
    res.port_a_drive        = lat_a & ddr_a;
    res.port_b_drive        = lat_b & ddr_b;
    res.port_c_drive        = ctrl_reg[CTRL_INT_MODE] ? 8'h00 : (lat_c & ddr_c);
    res.port_c_drive_enable = !ctrl_reg[CTRL_INT_MODE];
    res.ca_out              = ca_lvl;
    res.cb_out              = cb_lvl;
    return res;
  endfunction

  // every field random, so unused fields toggle too
  function automatic in_t any_op();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return in_t'(r[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t bus_rd(logic [2:0] addr, logic [7:0] ext);
    in_t it;
    it = any_op();
    it.mode = MODE_READ;
    it.reg_addr = addr;
    it.ext_read = ext;
    return it;
  endfunction

  function automatic in_t bus_wr(logic [2:0] addr, logic [7:0] data);
    in_t it;
    it = any_op();
    it.mode = MODE_WRITE;
    it.reg_addr = addr;
    it.write_data = data;
    return it;
  endfunction

  function automatic in_t line_op(logic [2:0] idx, logic lvl);
    in_t it;
    it = any_op();
    it.mode = MODE_LINE;
    it.line_index = idx;
    it.line_level = lvl;
    return it;
  endfunction

  function automatic in_t pin_op(logic [1:0] port, logic [7:0] val);
    in_t it;
    it = any_op();
    it.mode = MODE_PIN;
    it.pin_port = port;
    it.pin_value = val;
    return it;
  endfunction

  task automatic queue_op(in_t it);
    pending_ops.push_back(it);
    mode_cnt[it.mode]++;
    if (!((it.mode == MODE_LINE && it.line_index > LINE_MAX) ||
          (it.mode == MODE_PIN && it.pin_port > PIN_PORT_C) ||
          (it.mode == MODE_WRITE && it.reg_addr == ADDR_AIR)))
      eff_cnt++;
  endtask

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    if (err_cnt < PRINT_CAP)
      $display("result %0d: %s got %02h, want %02h", outs_checked, field, got, want);
    err_cnt++;
  endtask

  // idle rates: phase 0 slow receiver, phase 1 slow sender, phase 2 none
  function automatic int idle_pct(logic rx_side);
    if (ops_sent < ops_total / 3) return rx_side ? 77 : 19;
    if (ops_sent < 2 * ops_total / 3) return rx_side ? 19 : 77;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_outs.push_back(adapter_step(in_data));
        ops_sent <= ops_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outs.size() == 0) begin
          if (err_cnt < PRINT_CAP) $display("result %0d arrived with none predicted", outs_checked);
          err_cnt++;
        end else begin
          want = predicted_outs.pop_front();
          if (out_data.read_data !== want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.irq_out !== want.irq_out)
            report_mismatch("irq_out", 8'(out_data.irq_out), 8'(want.irq_out));
          if (out_data.port_a_drive !== want.port_a_drive)
            report_mismatch("port_a_drive", out_data.port_a_drive, want.port_a_drive);
          if (out_data.port_b_drive !== want.port_b_drive)
            report_mismatch("port_b_drive", out_data.port_b_drive, want.port_b_drive);
          if (out_data.port_c_drive !== want.port_c_drive)
            report_mismatch("port_c_drive", out_data.port_c_drive, want.port_c_drive);
          if (out_data.port_c_drive_enable !== want.port_c_drive_enable)
            report_mismatch("port_c_drive_enable", 8'(out_data.port_c_drive_enable),
                            8'(want.port_c_drive_enable));
          if (out_data.ca_out !== want.ca_out)
            report_mismatch("ca_out", 8'(out_data.ca_out), 8'(want.ca_out));
          if (out_data.cb_out !== want.cb_out)
            report_mismatch("cb_out", 8'(out_data.cb_out), 8'(want.cb_out));
        end
        outs_checked <= outs_checked + 1;
      end
      // one long back-pressure stretch while the sender runs flat out
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && ops_sent >= 5 * ops_total / 6) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= idle_pct(1'b1);
      end
    end
  end

  // watchdog
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("triple_port_interface_adapter: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n, k, start_eff;
    logic [7:0] d, e;

    lat_a = '0; lat_b = '0; lat_c = '0;
    ddr_a = '0; ddr_b = '0; ddr_c = '0;
    ctrl_reg = '0;
    irq_pend = '0;
    irq_flag = 1'b0;
    lines = '0;
    pins[0] = 8'hff; pins[1] = 8'hff; pins[2] = 8'hff;
    ca_lvl = 1'b0; cb_lvl = 1'b0;
    foreach (mode_cnt[i]) mode_cnt[i] = 0;

    // directed
    queue_op(bus_rd(ADDR_PORT_A, 8'hff));
    queue_op(bus_wr(ADDR_DIR_A, 8'hff));
    queue_op(bus_wr(ADDR_PORT_A, 8'hff));
    queue_op(bus_wr(ADDR_DIR_B, 8'h0f));
    queue_op(bus_wr(ADDR_PORT_B, 8'ha5));
    queue_op(pin_op(PIN_PORT_B, 8'h3c));
    queue_op(bus_rd(ADDR_PORT_B, 8'hf0));
    queue_op(pin_op(PIN_NONE, 8'h00));
    queue_op(line_op(3'd0, 1'b1));            // outside interrupt mode
    queue_op(bus_wr(ADDR_CTRL, 8'hb1));       // int mode, CA forced high, CB forced low
    queue_op(bus_wr(ADDR_PORT_C, 8'h5a));     // stored, not driven
    queue_op(bus_wr(ADDR_DIR_C, 8'h1f));
    queue_op(line_op(3'd0, 1'b1));
    queue_op(line_op(3'd0, 1'b0));            // falling edge latches
    queue_op(line_op(3'd0, 1'b0));            // same level
    queue_op(line_op(LINE_NONE, 1'b1));
    queue_op(bus_rd(ADDR_PORT_C, 8'hff));
    queue_op(bus_wr(ADDR_CTRL, 8'h0f));       // prioritized, rising edge on lines 3 and 4
    queue_op(line_op(LINE_3, 1'b1));
    queue_op(line_op(LINE_4, 1'b1));
    repeat (4) queue_op(bus_rd(ADDR_AIR, 8'hff));
    queue_op(bus_wr(ADDR_AIR, 8'hff));
    queue_op(bus_wr(ADDR_CTRL, 8'hf1));
    queue_op(line_op(LINE_4, 1'b0));
    queue_op(bus_rd(ADDR_AIR, 8'h00));
    queue_op(bus_rd(ADDR_AIR, 8'h00));        // nothing left pending
    queue_op(bus_wr(ADDR_CTRL, 8'h00));
    queue_op(bus_rd(ADDR_CTRL, 8'h00));

    // random: mostly interrupt sessions, some raw noise
    start_eff = eff_cnt;
    while (eff_cnt - start_eff < RANDOM_OPS) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_op(any_op());
      end else begin
        d = 8'($urandom);
        if ($urandom_range(0, 3) != 0) d[CTRL_INT_MODE] = 1'b1;
        queue_op(bus_wr(ADDR_CTRL, d));
        if ($urandom_range(0, 1) == 1) begin
          d = 8'($urandom);
          if ($urandom_range(0, 1) == 1) d[4:0] = 5'h1f;
          queue_op(bus_wr(ADDR_DIR_C, d));
        end
        n = $urandom_range(4, 12);
        repeat (n) begin
          k = $urandom_range(0, 9);
          e = ($urandom_range(0, 1) == 1) ? READ_IDLE : 8'($urandom);
          if (k < 5)
            queue_op(line_op(3'($urandom_range(0, 4)), 1'($urandom_range(0, 1))));
          else if (k < 7)
            queue_op(bus_rd(ADDR_AIR, e));
          else if (k == 7)
            queue_op(bus_rd(3'($urandom), e));
          else if (k == 8)
            queue_op(bus_wr(3'($urandom), 8'($urandom)));
          else
            queue_op(pin_op(2'($urandom_range(0, 2)), 8'($urandom)));
        end
      end
    end
    ops_total = pending_ops.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (ops_sent != ops_total || predicted_outs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d bus reads, %0d bus writes, %0d line changes, %0d pin updates",
             mode_cnt[MODE_READ], mode_cnt[MODE_WRITE], mode_cnt[MODE_LINE],
             mode_cnt[MODE_PIN]);
    $display("%0d results checked, %0d interrupts latched, %0d field errors",
             outs_checked, irq_takes, err_cnt);
    if (err_cnt == 0)
      $display("triple_port_interface_adapter: match");
    else
      $display("triple_port_interface_adapter: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/tpia_pkg.sv
sv/triple_port_interface_adapter.sv
tb/sv/testbench.sv
